### src/pid_controller_with_settle_check_core_defines.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_WITH_SETTLE_CHECK_CORE_DEFINES_SVH
`define PID_CONTROLLER_WITH_SETTLE_CHECK_CORE_DEFINES_SVH

// Same-cycle implication
`define PIDSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidsc assertion failed");

// Next-cycle implication
`define PIDSC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidsc assertion failed");

`endif

### src/pidsc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes and unit interface types for the PID core.
// ----------------------------------------------------------------------------
package pidsc_pkg;

    // Field and register widths
    localparam int DATA_WIDTH  = 16;
    localparam int ACC_WIDTH   = 48;
    localparam int GAIN_W      = 24;
    localparam int PERIOD_W    = 16;
    localparam int ERR_TOL_W   = 16;
    localparam int RATE_TOL_W  = 32;
    localparam int DRIVE_W     = 32;
    localparam int DERIV_W     = 40;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Fixed-point scaling
    localparam int FRAC_D   = 16;   // derivative numerator scale
    localparam int FRAC_I   = 16;   // integral fraction bits
    localparam int FRAC_OUT = 12;   // gain fraction bits

    // Derived widths
    localparam int ERR_W   = DATA_WIDTH + 1;
    localparam int DIFF_W  = DATA_WIDTH + 2;
    localparam int MAG_W   = DIFF_W - 1 + FRAC_D;
    localparam int NUM_W   = MAG_W + 1;
    localparam int DEXT_W  = (NUM_W > DERIV_W) ? NUM_W : DERIV_W;
    localparam int INTEG_W = ACC_WIDTH - FRAC_I;
    localparam int MUL_B_W = (DERIV_W > INTEG_W) ? DERIV_W : INTEG_W;
    localparam int MUL_P_W = GAIN_W + MUL_B_W;
    localparam int INT_SUM_W  = ((ACC_WIDTH > MUL_P_W) ? ACC_WIDTH : MUL_P_W) + 1;
    localparam int SUM_W      = MUL_P_W + 2;
    localparam int ETOL_CMP_W = (ERR_W > ERR_TOL_W) ? ERR_W : ERR_TOL_W;
    localparam int DTOL_CMP_W = (DERIV_W > RATE_TOL_W) ? DERIV_W : RATE_TOL_W;
    localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_PERIOD    = 3'd3,
        REG_ERR_TOL   = 3'd4,
        REG_RATE_TOL  = 3'd5
    } cfg_reg_t;

    // Divider request and status
    typedef struct packed {
        logic                start;
        logic [MAG_W-1:0]    dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
    } div_stat_t;

endpackage

### src/pidsc_divider.sv
// ----------------------------------------------------------------------------
// PID derivative divider
// Restoring unsigned divider, one quotient bit per cycle, zero divisor as one.
// ----------------------------------------------------------------------------
module pidsc_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pidsc_pkg::div_req_t  req,
    output pidsc_pkg::div_stat_t stat
);
    import pidsc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [PERIOD_W-1:0]  rem_reg;
    logic [MAG_W-1:0]     quo_reg;
    logic [PERIOD_W-1:0]  dvs_reg;

    logic [PERIOD_W:0]    rem_shift;
    logic [PERIOD_W+1:0]  trial;
    logic                 fits;
    logic [PERIOD_W-1:0]  rem_next;
    logic [MAG_W-1:0]     quo_next;

    // One restoring step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[MAG_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};
        fits      = ~trial[PERIOD_W+1];
        rem_next  = fits ? trial[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
        quo_next  = {quo_reg[MAG_W-2:0], fits};
    end

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(MAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= (req.divisor == '0) ? PERIOD_W'(1) : req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

### src/pid_controller_with_settle_check_core.sv
// ----------------------------------------------------------------------------
// PID controller with settle check
// Fixed-point PID step per sample with a settled flag, one shared multiplier.
// ----------------------------------------------------------------------------
// One sample is taken at a time, and the next input transfer waits until the
// result is posted. Each sample forms its derivative with the 33-step restoring
// divider; the first sample after reset or after a restart skips the division.
// The four products (integral increment and the three gain terms) share one
// 24 x 40 signed multiplier, one per cycle.
// The output register holds a result until taken, and a new sample is taken
// meanwhile; a finished sample waits only if the previous result is still held.
module pid_controller_with_settle_check_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration
    input  logic                                  cfg_write,
    input  logic [pidsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pidsc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Sample input
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pidsc_pkg::DATA_WIDTH-1:0] target,
    input  logic signed [pidsc_pkg::DATA_WIDTH-1:0] measurement,
    input  logic                                  restart,
    // Result output
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pidsc_pkg::DRIVE_W-1:0]  drive,
    output logic                                  settled
);
    import pidsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_INC,
        S_ACC_INT,
        S_DIV_WAIT,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_OUT
    } state_t;

    // Configuration registers
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic [PERIOD_W-1:0]      period_reg;
    logic [ERR_TOL_W-1:0]     err_tol_reg;
    logic [RATE_TOL_W-1:0]    rate_tol_reg;

    // Sequencer and datapath registers
    state_t                      state_reg;
    logic                        first_reg;
    logic                        first_cur_reg;
    logic signed [ACC_WIDTH-1:0] integral_reg;
    logic signed [ERR_W-1:0]     prev_err_reg;
    logic signed [ERR_W-1:0]     err_reg;
    logic signed [DERIV_W-1:0]   deriv_reg;
    logic                        neg_reg;
    logic signed [MUL_P_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]     acc_reg;
    logic signed [DRIVE_W-1:0]   drive_reg;
    logic                        settled_reg;
    logic                        out_valid_reg;

    // Combinational datapath
    logic signed [ERR_W-1:0]     err_in;
    logic signed [DIFF_W-1:0]    diff;
    logic [DIFF_W-1:0]           diff_mag;
    logic signed [GAIN_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0]   mul_p;
    logic signed [INTEG_W-1:0]   integ;
    logic signed [INT_SUM_W-1:0] int_sum;
    logic [INT_SUM_W-ACC_WIDTH:0] int_top;
    logic signed [ACC_WIDTH-1:0] int_sat;
    logic signed [NUM_W-1:0]     q_signed;
    logic signed [DEXT_W-1:0]    q_ext;
    logic [DEXT_W-DERIV_W:0]     q_top;
    logic signed [DERIV_W-1:0]   deriv_sat;
    logic signed [SUM_W-1:0]     final_sum;
    logic [SUM_W-FRAC_OUT-DRIVE_W:0] out_top;
    logic signed [DRIVE_W-1:0]   drive_sat;
    logic [ERR_W-1:0]            err_mag;
    logic [DERIV_W-1:0]          deriv_mag;
    logic                        settled_now;
    logic                        out_free;

    div_req_t  div_req;
    div_stat_t div_stat;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            period_reg   <= PERIOD_W'(655);
            err_tol_reg  <= '0;
            rate_tol_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:   gain_p_reg   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:   gain_i_reg   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:   gain_d_reg   <= cfg_data[GAIN_W-1:0];
                REG_PERIOD:   period_reg   <= cfg_data[PERIOD_W-1:0];
                REG_ERR_TOL:  err_tol_reg  <= cfg_data[ERR_TOL_W-1:0];
                REG_RATE_TOL: rate_tol_reg <= cfg_data[RATE_TOL_W-1:0];
                default:      ;
            endcase
        end
    end

    // Error and derivative numerator
    always_comb
    begin
        err_in   = ERR_W'(target) - ERR_W'(measurement);
        diff     = DIFF_W'(prev_err_reg) - DIFF_W'(err_reg);
        diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    end

    assign div_req.start    = (state_reg == S_MUL_INC) && !first_cur_reg;
    assign div_req.dividend = {diff_mag[DIFF_W-2:0], {FRAC_D{1'b0}}};
    assign div_req.divisor  = period_reg;

    pidsc_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // Signed quotient, saturated to the derivative width
    always_comb
    begin
        q_signed  = neg_reg ? NUM_W'(-$signed({1'b0, div_stat.quotient}))
                            : $signed({1'b0, div_stat.quotient});
        q_ext     = DEXT_W'(q_signed);
        q_top     = q_ext[DEXT_W-1:DERIV_W-1];
        if ((&q_top) || (~|q_top))
            deriv_sat = q_ext[DERIV_W-1:0];
        else if (q_ext[DEXT_W-1])
            deriv_sat = {1'b1, {(DERIV_W-1){1'b0}}};
        else
            deriv_sat = {1'b0, {(DERIV_W-1){1'b1}}};
    end

    // Shared multiplier operand select
    assign integ = $signed(integral_reg[ACC_WIDTH-1:FRAC_I]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL_INC:
            begin
                mul_a = GAIN_W'({1'b0, period_reg});
                mul_b = MUL_B_W'(err_reg);
            end
            S_MUL_P:
            begin
                mul_a = gain_p_reg;
                mul_b = MUL_B_W'(err_reg);
            end
            S_MUL_I:
            begin
                mul_a = gain_i_reg;
                mul_b = MUL_B_W'(integ);
            end
            S_MUL_D:
            begin
                mul_a = gain_d_reg;
                mul_b = MUL_B_W'(deriv_reg);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Integral update with saturation
    always_comb
    begin
        int_sum = INT_SUM_W'(integral_reg) + INT_SUM_W'(prod_reg);
        int_top = int_sum[INT_SUM_W-1:ACC_WIDTH-1];
        if ((&int_top) || (~|int_top))
            int_sat = int_sum[ACC_WIDTH-1:0];
        else if (int_sum[INT_SUM_W-1])
            int_sat = {1'b1, {(ACC_WIDTH-1){1'b0}}};
        else
            int_sat = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end

    // Final sum, floor shift and drive saturation
    always_comb
    begin
        final_sum = acc_reg - SUM_W'(prod_reg);
        out_top   = final_sum[SUM_W-1:FRAC_OUT+DRIVE_W-1];
        if ((&out_top) || (~|out_top))
            drive_sat = final_sum[FRAC_OUT+DRIVE_W-1:FRAC_OUT];
        else if (final_sum[SUM_W-1])
            drive_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
        else
            drive_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end

    // Settle check
    always_comb
    begin
        err_mag     = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
        deriv_mag   = deriv_reg[DERIV_W-1] ? DERIV_W'(-deriv_reg) : DERIV_W'(deriv_reg);
        settled_now = (ETOL_CMP_W'(err_mag) < ETOL_CMP_W'(err_tol_reg))
                   && (DTOL_CMP_W'(deriv_mag) < DTOL_CMP_W'(rate_tol_reg));
    end

    assign out_free = !out_valid_reg || out_ready;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b1;
            first_cur_reg <= 1'b0;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            err_reg       <= '0;
            deriv_reg     <= '0;
            neg_reg       <= 1'b0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
            settled_reg   <= 1'b0;
        end
        else
        begin
            // S_OUT reloads the output register itself
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        err_reg       <= err_in;
                        first_cur_reg <= first_reg | restart;
                        first_reg     <= 1'b0;
                        if (restart)
                            integral_reg <= '0;
                        state_reg <= S_MUL_INC;
                    end
                end
                S_MUL_INC:
                begin
                    prod_reg     <= mul_p;
                    prev_err_reg <= err_reg;
                    neg_reg      <= diff[DIFF_W-1];
                    state_reg    <= S_ACC_INT;
                end
                S_ACC_INT:
                begin
                    integral_reg <= int_sat;
                    if (first_cur_reg)
                    begin
                        deriv_reg <= '0;
                        state_reg <= S_MUL_P;
                    end
                    else
                        state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        deriv_reg <= deriv_sat;
                        state_reg <= S_MUL_P;
                    end
                end
                S_MUL_P:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MUL_I;
                end
                S_MUL_I:
                begin
                    acc_reg   <= SUM_W'(prod_reg);
                    prod_reg  <= mul_p;
                    state_reg <= S_MUL_D;
                end
                S_MUL_D:
                begin
                    acc_reg   <= acc_reg + SUM_W'(prod_reg);
                    prod_reg  <= mul_p;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        drive_reg     <= drive_sat;
                        settled_reg   <= settled_now;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign settled   = settled_reg;

endmodule

### src/pidsc_checker.sv
// ----------------------------------------------------------------------------
// PID controller port checker
// Handshake and sequencing checks on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
`include "pid_controller_with_settle_check_core_defines.svh"

module pidsc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [pidsc_pkg::DRIVE_W-1:0] drive,
    input logic                                 settled
);
    import pidsc_pkg::*;

    // A held result keeps its value until the transfer
    `PIDSC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive) && $stable(settled))

    // One sample at a time: busy right after an input transfer
    `PIDSC_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)

    // A new result only ends a sample in progress, and frees the input
    `PIDSC_ASSERT_IMP(a_result_ends_item, $rose(out_valid), in_ready && $past(!in_ready))

    // Ready drops only because a sample was taken
    `PIDSC_ASSERT_IMP(a_ready_drop_on_take, $fell(in_ready), $past(in_valid))

endmodule

bind pid_controller_with_settle_check_core pidsc_checker u_pidsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .settled   (settled)
);
